/* hdl/chm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants and types of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int MAX_BUCKETS  = 64;
  localparam int POOL_ENTRIES = 256;
  localparam int BKT_W        = $clog2(MAX_BUCKETS);
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int CFG_W        = 7;
  localparam int WORD_W       = 64;
  localparam logic [CFG_W-1:0] DEFAULT_BUCKETS = CFG_W'(16);

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [WORD_W-1:0]  key;
    logic [WORD_W-1:0]  value;
    logic [BKT_W-1:0]   bucket;
  } op_t;

endpackage

/* hdl/chained_hash_map_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_unit
// Key-value map with separate chaining over a pool of 256 entries.
// ----------------------------------------------------------------------------
// An operation passes through the front end, where the 64-bit key is
// reduced modulo the bucket count eight bits a cycle, then waits in a
// two-word queue for the back end. The back end goes straight to its action
// step when the bucket is empty, otherwise it first reads the chain head and
// compares chain entries one at a time; a set that reuses a freed entry also
// passes through a pop state, and clear is applied from the idle state. Front
// and back overlap. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module chained_hash_map_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_action,
  input  logic [chm_pkg::WORD_W-1:0]  in_key,
  input  logic [chm_pkg::WORD_W-1:0]  in_value,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_found,
  output logic [chm_pkg::WORD_W-1:0]  out_found_value,
  output logic [chm_pkg::CNT_W-1:0]   out_entry_count,
  output logic                        out_status,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [chm_pkg::CFG_W-1:0] bucket_count_r;
  chm_pkg::op_t              q_op;
  logic                      q_valid;
  logic                      q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ?
                      {{(32 - chm_pkg::CFG_W){1'b0}}, bucket_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= chm_pkg::DEFAULT_BUCKETS;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      bucket_count_r <= cfg_pwdata[chm_pkg::CFG_W-1:0];
    end
  end

  chm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_action(in_action), .in_key(in_key), .in_value(in_value),
    .bucket_count(bucket_count_r),
    .q_op(q_op), .q_valid(q_valid), .q_pop(q_pop)
  );

  chm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_op(q_op), .q_valid(q_valid), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_found(out_found), .out_found_value(out_found_value),
    .out_entry_count(out_entry_count), .out_status(out_status)
  );

endmodule

/* hdl/chm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/chm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_front
// Accepts operations, reduces the key modulo the bucket count eight bits a
// cycle, and queues the classified operation for the back end.
// ----------------------------------------------------------------------------
module chm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [1:0]                in_action,
  input  logic [chm_pkg::WORD_W-1:0] in_key,
  input  logic [chm_pkg::WORD_W-1:0] in_value,
  input  logic [chm_pkg::CFG_W-1:0] bucket_count,
  output chm_pkg::op_t              q_op,
  output logic                      q_valid,
  input  logic                      q_pop
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t                    state_r;
  chm_pkg::op_t               op_r;
  logic [chm_pkg::WORD_W-1:0] kshift_r;
  logic [chm_pkg::CFG_W-1:0]  div_r;
  logic [chm_pkg::CFG_W-1:0]  rem_r, rem_nxt;
  logic [2:0]                 cnt_r;
  logic [chm_pkg::CFG_W-1:0]  n_clamped;

  chm_pkg::op_t q_mem [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   q_cnt_r;
  logic         q_push;

  always_comb begin
    if (bucket_count == '0) begin
      n_clamped = chm_pkg::CFG_W'(1);
    end else if (bucket_count > chm_pkg::CFG_W'(chm_pkg::MAX_BUCKETS)) begin
      n_clamped = chm_pkg::CFG_W'(chm_pkg::MAX_BUCKETS);
    end else begin
      n_clamped = bucket_count;
    end
  end

  // restoring remainder, eight key bits per cycle
  always_comb begin
    logic [chm_pkg::CFG_W-1:0] t;
    t = rem_r;
    for (int i = 0; i < 8; i++) begin
      t = {t[chm_pkg::CFG_W-2:0], kshift_r[chm_pkg::WORD_W-1-i]};
      if (t >= div_r) begin
        t = t - div_r;
      end
    end
    rem_nxt = t;
  end

  assign in_full = (state_r != F_IDLE);
  assign q_push  = (state_r == F_PUSH) && (q_cnt_r != 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_push) begin
            op_r.action <= chm_pkg::action_t'(in_action);
            op_r.key    <= in_key;
            op_r.value  <= in_value;
            kshift_r    <= in_key;
            div_r       <= n_clamped;
            rem_r       <= '0;
            cnt_r       <= '0;
            state_r     <= F_DIV;
          end
        end
        F_DIV: begin
          rem_r    <= rem_nxt;
          kshift_r <= {kshift_r[chm_pkg::WORD_W-9:0], 8'd0};
          cnt_r    <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            op_r.bucket <= rem_nxt[chm_pkg::BKT_W-1:0];
            state_r     <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_push) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wr_ptr_r] <= op_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

  assign q_op    = q_mem[rd_ptr_r];
  assign q_valid = (q_cnt_r != 2'd0);

endmodule

/* hdl/chm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_back
// Walks the bucket chain, applies lookup, set, remove or clear, and holds
// the result word until it is popped.
// ----------------------------------------------------------------------------
module chm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  chm_pkg::op_t                q_op,
  input  logic                        q_valid,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_found,
  output logic [chm_pkg::WORD_W-1:0]  out_found_value,
  output logic [chm_pkg::CNT_W-1:0]   out_entry_count,
  output logic                        out_status
);

  localparam int IW = chm_pkg::IDX_W;
  localparam int CW = chm_pkg::CNT_W;
  localparam int WW = chm_pkg::WORD_W;
  localparam logic [CW-1:0] NO_ENTRY = CW'(chm_pkg::POOL_ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_CMP, S_ACT, S_POP} bstate_t;

  bstate_t         state_r;
  chm_pkg::op_t    op_r;
  logic [chm_pkg::MAX_BUCKETS-1:0] used_r;
  logic [IW-1:0]   cur_r, hidx_r, head_r;
  logic [CW-1:0]   prev_r, hnxt_r;
  logic [WW-1:0]   hval_r;
  logic            hit_r;
  logic [IW-1:0]   steps_r;
  logic [CW-1:0]   free_top_r, fresh_r, held_r;
  logic            out_valid_r, found_r, status_r;
  logic [WW-1:0]   fval_r;

  logic [IW-1:0]   rd_addr;
  logic [WW-1:0]   key_rd, val_rd;
  logic [CW-1:0]   nxt_rd;
  logic [IW-1:0]   fs_rd, head_rd;
  logic [IW-1:0]   slot;
  logic            do_link, do_remove;

  logic            key_we, val_we, nxt_we, fs_we, head_we;
  logic [IW-1:0]   val_wa, nxt_wa, fs_ra;
  logic [WW-1:0]   val_wd;
  logic [CW-1:0]   nxt_wd;
  logic [IW-1:0]   head_wd;

  // ---- link and unlink decisions
  always_comb begin
    do_link   = 1'b0;
    do_remove = 1'b0;
    slot      = fresh_r[IW-1:0];
    if (state_r == S_POP) begin
      do_link = 1'b1;
      slot    = fs_rd;
    end else if (state_r == S_ACT) begin
      if (op_r.action == chm_pkg::ACT_SET && !hit_r && free_top_r == '0 &&
          fresh_r < NO_ENTRY) begin
        do_link = 1'b1;
      end
      if (op_r.action == chm_pkg::ACT_REMOVE && hit_r) begin
        do_remove = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_HEAD:  rd_addr = head_rd;
      S_CMP:   rd_addr = nxt_rd[IW-1:0];
      default: rd_addr = cur_r;
    endcase
    fs_ra   = IW'(free_top_r - CW'(1));

    key_we  = do_link;
    val_we  = do_link ||
              (state_r == S_ACT && op_r.action == chm_pkg::ACT_SET && hit_r);
    val_wa  = do_link ? slot : hidx_r;
    val_wd  = op_r.value;
    nxt_we  = do_link || (do_remove && !prev_r[IW]);
    nxt_wa  = do_link ? slot : prev_r[IW-1:0];
    nxt_wd  = do_link ? (used_r[op_r.bucket] ? {1'b0, head_r} : NO_ENTRY) : hnxt_r;
    head_we = do_link || (do_remove && prev_r[IW] && !hnxt_r[IW]);
    head_wd = do_link ? slot : hnxt_r[IW-1:0];
    fs_we   = do_remove && !free_top_r[IW];
  end

  chm_ram #(.WIDTH(WW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(slot), .wdata(op_r.key),
    .raddr(rd_addr), .rdata(key_rd)
  );
  chm_ram #(.WIDTH(WW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
    .raddr(rd_addr), .rdata(val_rd)
  );
  chm_ram #(.WIDTH(CW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_nxt_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
    .raddr(rd_addr), .rdata(nxt_rd)
  );
  chm_ram #(.WIDTH(IW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_free_ram (
    .clk(clk), .we(fs_we), .waddr(free_top_r[IW-1:0]), .wdata(hidx_r),
    .raddr(fs_ra), .rdata(fs_rd)
  );
  chm_ram #(.WIDTH(IW), .DEPTH(chm_pkg::MAX_BUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(op_r.bucket), .wdata(head_wd),
    .raddr(q_op.bucket), .rdata(head_rd)
  );

  assign q_pop = (state_r == S_IDLE) && q_valid && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      free_top_r  <= '0;
      fresh_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            op_r  <= q_op;
            hit_r <= 1'b0;
            if (q_op.action == chm_pkg::ACT_CLEAR) begin
              used_r      <= '0;
              free_top_r  <= '0;
              fresh_r     <= '0;
              held_r      <= '0;
              found_r     <= 1'b0;
              fval_r      <= '0;
              status_r    <= 1'b0;
              out_valid_r <= 1'b1;
            end else if (!used_r[q_op.bucket]) begin
              state_r <= S_ACT;
            end else begin
              state_r <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          cur_r   <= head_rd;
          head_r  <= head_rd;
          prev_r  <= NO_ENTRY;
          steps_r <= '0;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (key_rd == op_r.key) begin
            hit_r   <= 1'b1;
            hidx_r  <= cur_r;
            hval_r  <= val_rd;
            hnxt_r  <= nxt_rd;
            state_r <= S_ACT;
          end else begin
            prev_r <= {1'b0, cur_r};
            if (nxt_rd[IW] || steps_r == '1) begin
              state_r <= S_ACT;
            end else begin
              cur_r   <= nxt_rd[IW-1:0];
              steps_r <= steps_r + IW'(1);
            end
          end
        end
        S_ACT: begin
          found_r  <= hit_r;
          fval_r   <= (op_r.action == chm_pkg::ACT_LOOKUP && hit_r) ? hval_r : '0;
          // refuse a new key when neither the free stack nor the fresh pool has room
          status_r <= (op_r.action == chm_pkg::ACT_SET) && !hit_r &&
                      (free_top_r == '0) && !do_link;
          if (op_r.action == chm_pkg::ACT_SET && !hit_r && free_top_r != '0) begin
            free_top_r <= free_top_r - CW'(1);
            state_r    <= S_POP;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
          if (do_link) begin
            fresh_r              <= fresh_r + CW'(1);
            used_r[op_r.bucket]  <= 1'b1;
            held_r               <= held_r + CW'(1);
          end
          if (do_remove) begin
            if (prev_r[IW] && hnxt_r[IW]) begin
              used_r[op_r.bucket] <= 1'b0;
            end
            if (!free_top_r[IW]) begin
              free_top_r <= free_top_r + CW'(1);
            end
            if (held_r != '0) begin
              held_r <= held_r - CW'(1);
            end
          end
        end
        S_POP: begin
          used_r[op_r.bucket] <= 1'b1;
          held_r              <= held_r + CW'(1);
          out_valid_r         <= 1'b1;
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_found       = found_r;
  assign out_found_value = fval_r;
  assign out_entry_count = held_r;
  assign out_status      = status_r;

`ifndef SYNTHESIS
  // every pool entry ever handed out is either held or on the free stack;
  // a reused entry is off the stack but not yet held during its link step
  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_POP) |-> ((free_top_r + held_r) == fresh_r))
    else $error("pool accounting broken");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ACT || state_r == S_POP ||
                                 (q_pop && q_op.action == chm_pkg::ACT_CLEAR)))
    else $error("result word raised outside an action step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> out_valid_r)
    else $error("pending result word dropped");

  a_link_fits: assert property (@(posedge clk) disable iff (!rst_n)
    do_link |-> (held_r < NO_ENTRY))
    else $error("link into a full pool");
`endif

endmodule
